[sv/swmj_pkg.sv]
package swmj_pkg;

  localparam int unsigned VAL_W   = 31;
  localparam int unsigned SCORE_W = 12;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned IDX_W   = 2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_MIN_JUMP = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_JUMP = 2'd1;

  localparam logic signed [VAL_W:0] VAL_MAX = 32'sd1073741823;
  localparam logic signed [VAL_W:0] VAL_MIN = -32'sd1073741824;

  typedef enum logic [1:0] {
    DQ_NONE,
    DQ_CLEAR,
    DQ_PUSH,
    DQ_EXPIRE
  } dq_op_e;

  typedef struct packed {
    dq_op_e op;
    logic   ge;
  } dq_ctl_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } dq_stat_t;

endpackage

[sv/swmj_deque.sv]
module swmj_deque import swmj_pkg::*; #(
  parameter int unsigned QCAP = 1026,
  parameter int unsigned PW   = 18,
  parameter int unsigned JW   = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dq_ctl_t                 ctl_i,
  input  logic [PW-1:0]           pos_i,
  input  logic signed [VAL_W-1:0] val_i,
  input  logic [JW-1:0]           lim_i,
  output dq_stat_t                stat_o,
  output logic signed [VAL_W-1:0] head_val_o
);

  localparam int unsigned QW = $clog2(QCAP);
  localparam int unsigned EW = PW + VAL_W;
  localparam logic [QW-1:0] QLAST = QW'(QCAP - 1);

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_PUSH_CMP,
    DS_EXP_CMP
  } dq_state_e;

  dq_state_e state_q;
  logic [QW-1:0] head_q, tail_q;
  logic signed [VAL_W-1:0] head_val_q;
  logic [EW-1:0] mem [QCAP];
  logic [EW-1:0] rd_q;

  logic [QW-1:0] rd_addr, waddr;
  logic          we;
  logic [PW-1:0] rpos, age, limx;
  logic signed [VAL_W-1:0] rval;
  logic          expired, empty;

  function automatic logic [QW-1:0] nxt(input logic [QW-1:0] k);
    return (k == QLAST) ? '0 : k + 1'b1;
  endfunction

  function automatic logic [QW-1:0] prv(input logic [QW-1:0] k);
    return (k == '0) ? QLAST : k - 1'b1;
  endfunction

  assign empty = (head_q == tail_q);
  assign rpos  = rd_q[EW-1:VAL_W];
  assign rval  = rd_q[VAL_W-1:0];
  assign age   = pos_i - rpos;
  assign limx  = PW'(lim_i);
  assign expired = ctl_i.ge ? (age >= limx) : (age > limx);

  always_comb begin
    case (state_q)
      DS_IDLE:     rd_addr = (ctl_i.op == DQ_EXPIRE) ? head_q : prv(tail_q);
      DS_PUSH_CMP: rd_addr = prv(prv(tail_q));
      DS_EXP_CMP:  rd_addr = nxt(head_q);
      default:     rd_addr = head_q;
    endcase
  end

  // write the new entry where the back-pop stops
  always_comb begin
    we    = 1'b0;
    waddr = tail_q;
    if (state_q == DS_IDLE && ctl_i.op == DQ_PUSH && empty) begin
      we = 1'b1;
    end else if (state_q == DS_PUSH_CMP) begin
      we = 1'b1;
      if (rval <= val_i) begin
        waddr = prv(tail_q);
        we    = (prv(tail_q) == head_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (we) begin
      mem[waddr] <= {pos_i, val_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= DS_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      head_val_q <= '0;
    end else begin
      case (state_q)
        DS_IDLE: begin
          case (ctl_i.op)
            DQ_CLEAR: begin
              head_q <= '0;
              tail_q <= '0;
            end
            DQ_PUSH: begin
              if (empty) tail_q <= nxt(tail_q);
              else state_q <= DS_PUSH_CMP;
            end
            DQ_EXPIRE: begin
              if (!empty) state_q <= DS_EXP_CMP;
            end
            default: ;
          endcase
        end
        DS_PUSH_CMP: begin
          if (rval <= val_i) begin
            if (prv(tail_q) == head_q) begin
              tail_q  <= nxt(prv(tail_q));
              state_q <= DS_IDLE;
            end else begin
              tail_q <= prv(tail_q);
            end
          end else begin
            tail_q  <= nxt(tail_q);
            state_q <= DS_IDLE;
          end
        end
        DS_EXP_CMP: begin
          if (expired) begin
            head_q <= nxt(head_q);
            if (nxt(head_q) == tail_q) state_q <= DS_IDLE;
          end else begin
            head_val_q <= rval;
            state_q    <= DS_IDLE;
          end
        end
        default: state_q <= DS_IDLE;
      endcase
    end
  end

  assign stat_o.busy  = (state_q != DS_IDLE);
  assign stat_o.empty = empty;
  assign head_val_o   = head_val_q;

  a_cmd_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.op != DQ_NONE |-> state_q == DS_IDLE) else $error("deque command while busy");
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= QLAST && tail_q <= QLAST) else $error("deque pointer out of range");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == DS_IDLE && ctl_i.op == DQ_PUSH && empty |=> !empty)
    else $error("push into empty deque lost");

endmodule

[sv/sliding_window_max_jump_dp.sv]
// Sliding window max-jump scorer.
// Input channel (in_valid_i/in_ready_o): one signed score word per position,
// last_i marks the final position of a sequence. Positions count from 0.
// Output channel (out_valid_o/out_ready_i): one result word per input word,
// carrying best_here/reachable, and on the last word answer/answer_valid.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 = min_jump,
// index 1 = max_jump; other indexes are dropped. Write only while idle.
// Each item walks the ring read, window push and expire, ring write, answer
// expire and push, on a last word an answer expire and peek, then the result
// load. Skipping the window lookup shortens this; each entry popped from
// either deque lengthens it, through the back-pop and front-expire loops of
// the two deque sequencers, each with one registered memory read per step. One
// item is in flight at a time; in_ready_o is high only when the sequencer is idle,
// from the cycle after the result is loaded. Pops amortize to about one per item.
// A finished result sits in the output register; if the receiver stalls,
// the next item may be taken and worked on, and it holds at the end until
// the output register frees up.
// Reset clears min_jump/max_jump to 1, empties both deques and restarts at
// position 0. No clearing pass: ring entries are written before read.
module sliding_window_max_jump_dp import swmj_pkg::*; #(
  parameter int unsigned MAX_JUMP = 1024,
  parameter int unsigned MAX_LEN  = 262144
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VAL_W-1:0] best_here_o,
  output logic                    reachable_o,
  output logic signed [VAL_W-1:0] answer_o,
  output logic                    answer_valid_o,
  output logic                    done_res_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned RD   = MAX_JUMP + 1;    // ring depth
  localparam int unsigned QCAP = MAX_JUMP + 2;    // deque capacity
  localparam int unsigned RW   = $clog2(RD);
  localparam int unsigned SW   = $clog2(RD + 1);
  localparam int unsigned JW   = $clog2(MAX_JUMP + 1);
  // position only needs to resolve ages a little past MAX_JUMP
  localparam int unsigned PW   = ($clog2(MAX_LEN) > $clog2(MAX_JUMP) + 2) ?
                                 $clog2(MAX_LEN) : $clog2(MAX_JUMP) + 2;
  localparam logic [RW-1:0] RLAST = RW'(RD - 1);
  localparam logic [SW-1:0] SMAX  = SW'(RD);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RING,
    ST_RDATA,
    ST_WPUSH_W,
    ST_WEXP,
    ST_WEXP_W,
    ST_WRING,
    ST_AEXP_W,
    ST_APUSH_W,
    ST_AFIN,
    ST_APEEK_W,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic [CFG_W-1:0] min_jump_q, max_jump_q;
  logic [JW-1:0]    a_q, b_q;
  logic signed [SCORE_W-1:0] score_q;
  logic             last_q, reach_q, ans_valid_q;
  logic signed [VAL_W-1:0] val_q, ans_q;
  logic [PW-1:0]    position_q;
  logic [RW-1:0]    ring_cur_q;
  logic [SW-1:0]    seen_q;

  logic [VAL_W:0]   ring [RD];
  logic [VAL_W:0]   ring_rd_q;
  logic [RW-1:0]    ring_raddr;
  logic             ring_we;

  logic             out_valid_q, reach_o_q, ans_valid_o_q, done_o_q;
  logic signed [VAL_W-1:0] best_o_q, ans_o_q;

  dq_ctl_t  wctl, actl;
  dq_stat_t wstat, astat;
  logic [PW-1:0] wpos;
  logic signed [VAL_W-1:0] whead, ahead;
  logic signed [VAL_W+1:0] sum;
  logic signed [VAL_W-1:0] sat;
  logic out_free;

  function automatic logic [JW-1:0] clamp_jump(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd1) w = 32'd1;
    if (w > 32'(MAX_JUMP)) w = 32'(MAX_JUMP);
    return w[JW-1:0];
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // ring slot of position - min_jump
  always_comb begin
    logic [31:0] cur, idx;
    cur = 32'(ring_cur_q);
    idx = (cur >= 32'(a_q)) ? cur - 32'(a_q) : cur + 32'(RD) - 32'(a_q);
    ring_raddr = idx[RW-1:0];
  end

  assign ring_we = (state_q == ST_WRING);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RING) ring_rd_q <= ring[ring_raddr];
    if (ring_we) ring[ring_cur_q] <= {reach_q, reach_q ? val_q : VAL_W'(0)};
  end

  // window head plus score, saturated
  assign sum = (VAL_W+2)'(whead) + (VAL_W+2)'(score_q);
  always_comb begin
    if (sum > (VAL_W+2)'(VAL_MAX))      sat = VAL_MAX[VAL_W-1:0];
    else if (sum < (VAL_W+2)'(VAL_MIN)) sat = VAL_MIN[VAL_W-1:0];
    else                                sat = sum[VAL_W-1:0];
  end

  // deque commands
  always_comb begin
    wctl = '{op: DQ_NONE, ge: 1'b0};
    actl = '{op: DQ_NONE, ge: 1'b1};
    wpos = position_q;
    case (state_q)
      ST_RDATA: begin
        wpos = position_q - PW'(a_q);
        if (ring_rd_q[VAL_W]) wctl.op = DQ_PUSH;
      end
      ST_WPUSH_W: wpos = position_q - PW'(a_q);
      ST_WEXP:    wctl.op = DQ_EXPIRE;
      ST_WRING:   actl.op = DQ_EXPIRE;
      ST_AEXP_W:  if (!astat.busy && reach_q) actl.op = DQ_PUSH;
      ST_AFIN:    if (last_q) actl.op = DQ_EXPIRE;
      ST_EMIT: begin
        if (out_free && last_q) begin
          wctl.op = DQ_CLEAR;
          actl.op = DQ_CLEAR;
        end
      end
      default: ;
    endcase
  end

  // the ring word stays in ring_rd_q for the whole push
  swmj_deque #(.QCAP(QCAP), .PW(PW), .JW(JW)) u_win (
    .clk_i, .rst_ni,
    .ctl_i(wctl), .pos_i(wpos), .val_i(ring_rd_q[VAL_W-1:0]), .lim_i(b_q),
    .stat_o(wstat), .head_val_o(whead)
  );

  swmj_deque #(.QCAP(QCAP), .PW(PW), .JW(JW)) u_ans (
    .clk_i, .rst_ni,
    .ctl_i(actl), .pos_i(position_q), .val_i(val_q), .lim_i(b_q),
    .stat_o(astat), .head_val_o(ahead)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      min_jump_q    <= CFG_W'(1);
      max_jump_q    <= CFG_W'(1);
      position_q    <= '0;
      ring_cur_q    <= '0;
      seen_q        <= '0;
      out_valid_q   <= 1'b0;
      a_q           <= '0;
      b_q           <= '0;
      score_q       <= '0;
      last_q        <= 1'b0;
      reach_q       <= 1'b0;
      val_q         <= '0;
      ans_q         <= '0;
      ans_valid_q   <= 1'b0;
      best_o_q      <= '0;
      reach_o_q     <= 1'b0;
      ans_o_q       <= '0;
      ans_valid_o_q <= 1'b0;
      done_o_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MIN_JUMP: min_jump_q <= cfg_data_i;
          REG_MAX_JUMP: max_jump_q <= cfg_data_i;
          default: ;
        endcase
      end
      // in ST_EMIT a free output register is reloaded below
      if (out_valid_q && out_ready_i && state_q != ST_EMIT) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            score_q     <= score_i;
            last_q      <= last_i;
            a_q         <= clamp_jump(min_jump_q);
            b_q         <= clamp_jump(max_jump_q);
            ans_valid_q <= 1'b0;
            ans_q       <= '0;
            state_q     <= ST_RING;
          end
        end
        ST_RING: begin
          if (seen_q == '0) begin
            reach_q <= 1'b1;
            val_q   <= VAL_W'(score_q);
            state_q <= ST_WRING;
          end else if (a_q <= b_q && 32'(seen_q) >= 32'(a_q)) begin
            state_q <= ST_RDATA;
          end else begin
            state_q <= ST_WEXP;
          end
        end
        ST_RDATA:   state_q <= ring_rd_q[VAL_W] ? ST_WPUSH_W : ST_WEXP;
        ST_WPUSH_W: if (!wstat.busy) state_q <= ST_WEXP;
        ST_WEXP:    state_q <= ST_WEXP_W;
        ST_WEXP_W: begin
          if (!wstat.busy) begin
            reach_q <= !wstat.empty;
            val_q   <= sat;
            state_q <= ST_WRING;
          end
        end
        ST_WRING: state_q <= ST_AEXP_W;
        ST_AEXP_W: begin
          if (!astat.busy) state_q <= reach_q ? ST_APUSH_W : ST_AFIN;
        end
        ST_APUSH_W: if (!astat.busy) state_q <= ST_AFIN;
        ST_AFIN:    state_q <= last_q ? ST_APEEK_W : ST_EMIT;
        ST_APEEK_W: begin
          if (!astat.busy) begin
            ans_valid_q <= !astat.empty;
            ans_q       <= astat.empty ? VAL_W'(0) : ahead;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            best_o_q      <= reach_q ? val_q : VAL_W'(0);
            reach_o_q     <= reach_q;
            ans_o_q       <= ans_q;
            ans_valid_o_q <= ans_valid_q;
            done_o_q      <= last_q;
            if (last_q) begin
              position_q <= '0;
              ring_cur_q <= '0;
              seen_q     <= '0;
            end else begin
              position_q <= position_q + 1'b1;
              ring_cur_q <= (ring_cur_q == RLAST) ? '0 : ring_cur_q + 1'b1;
              if (seen_q < SMAX) seen_q <= seen_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign best_here_o    = best_o_q;
  assign reachable_o    = reach_o_q;
  assign answer_o       = ans_o_q;
  assign answer_valid_o = ans_valid_o_q;
  assign done_res_o     = done_o_q;

  a_answer_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && answer_valid_o |-> done_res_o) else $error("answer without last");
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reachable_o |-> best_here_o == '0) else $error("unreachable nonzero");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("second item taken");
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SMAX) else $error("seen count overflow");

endmodule

[verif/tb.sv]
`default_nettype none
module tb import swmj_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned JUMP_CAP = 1024;
  localparam int unsigned RING_N   = JUMP_CAP + 1;
  localparam int unsigned LIMIT    = 2_000_000;
  localparam int unsigned DRAIN    = 40;
  localparam int unsigned HOLD     = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SCORE_W-1:0] score_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VAL_W-1:0] best_here_o;
  logic reachable_o;
  logic signed [VAL_W-1:0] answer_o;
  logic answer_valid_o;
  logic done_res_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  sliding_window_max_jump_dp uut (.*);

  always #10 clk_i = ~clk_i;

  // one result word
  typedef struct packed {
    logic signed [VAL_W-1:0] best;
    logic reach;
    logic signed [VAL_W-1:0] ans;
    logic ans_ok;
    logic done;
  } score_res_t;

  // deque entry: position and value
  typedef struct {
    int unsigned pos;
    int val;
  } slot_t;

  score_res_t pending_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_answers = 0;
  bit long_hold = 1'b0;

  // scorer state mirror
  int unsigned min_jump_r, max_jump_r;
  int ring_val[RING_N];
  bit ring_ok[RING_N];
  slot_t win_q[$];
  slot_t ans_q[$];
  int unsigned pos_r, ring_cur, seen;

  function automatic int unsigned clamp_jump(int unsigned v);
    if (v < 1) return 1;
    if (v > JUMP_CAP) return JUMP_CAP;
    return v;
  endfunction

  function automatic void restart_seq();
    win_q.delete();
    ans_q.delete();
    pos_r = 0;
    ring_cur = 0;
    seen = 0;
  endfunction

  function automatic void push_mono(ref slot_t q[$], input int unsigned p, input int v);
    slot_t s;
    while (q.size() > 0 && q[$].val <= v) void'(q.pop_back());
    s.pos = p;
    s.val = v;
    q.push_back(s);
  endfunction

  // advance the scorer by one position and return its result word
  function automatic score_res_t score_step(logic signed [SCORE_W-1:0] sc, logic lst);
    score_res_t r;
    int unsigned a, b, idx;
    longint sum;
    bit reach;
    int v;
    a = clamp_jump(min_jump_r);
    b = clamp_jump(max_jump_r);
    v = 0;
    if (seen == 0) begin
      reach = 1'b1;
      v = int'(sc);
    end else begin
      if (a <= b && seen >= a) begin
        idx = (ring_cur >= a) ? ring_cur - a : ring_cur + RING_N - a;
        if (ring_ok[idx]) push_mono(win_q, pos_r - a, ring_val[idx]);
      end
      while (win_q.size() > 0 && pos_r - win_q[0].pos > b) void'(win_q.pop_front());
      reach = win_q.size() > 0;
      if (reach) begin
        sum = longint'(win_q[0].val) + longint'(sc);
        if (sum > VAL_MAX) sum = VAL_MAX;
        if (sum < VAL_MIN) sum = VAL_MIN;
        v = int'(sum);
      end
    end
    ring_val[ring_cur] = reach ? v : 0;
    ring_ok[ring_cur] = reach;
    while (ans_q.size() > 0 && pos_r - ans_q[0].pos >= b) void'(ans_q.pop_front());
    if (reach) push_mono(ans_q, pos_r, v);
    r.best = reach ? v[VAL_W-1:0] : '0;
    r.reach = reach;
    r.ans = '0;
    r.ans_ok = 1'b0;
    r.done = lst;
    if (lst) begin
      if (ans_q.size() > 0) begin
        r.ans = ans_q[0].val[VAL_W-1:0];
        r.ans_ok = 1'b1;
      end
      restart_seq();
    end else begin
      pos_r++;
      ring_cur = (ring_cur + 1 >= RING_N) ? 0 : ring_cur + 1;
      if (seen < RING_N) seen++;
    end
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off counted here
  initial begin : receiver
    int unsigned mode;
    int unsigned hold_n;
    mode = 0;
    hold_n = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold && hold_n < HOLD) begin
        out_ready_i <= 1'b0;
        hold_n++;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk_i) begin
    score_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result best=%0d", $time, best_here_o);
      end else begin
        e = pending_q.pop_front();
        if (e.ans_ok) n_answers++;
        if (best_here_o !== e.best || reachable_o !== e.reach || answer_o !== e.ans
            || answer_valid_o !== e.ans_ok || done_res_o !== e.done) begin
          errors++;
          $display("%0t: expected best=%0d reach=%0b ans=%0d ans_ok=%0b done=%0b",
                   $time, e.best, e.reach, e.ans, e.ans_ok, e.done);
          $display("%0t:   actual best=%0d reach=%0b ans=%0d ans_ok=%0b done=%0b",
                   $time, best_here_o, reachable_o, answer_o, answer_valid_o, done_res_o);
        end
      end
    end
  end

  // write one register while idle; mirror it right after the handshake
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MIN_JUMP) min_jump_r = data;
    else if (idx == REG_MAX_JUMP) max_jump_r = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  // offer one word, hold it until accepted, and queue its expectation;
  // valid stays high into the next word unless a gap is wanted
  task automatic send_word(logic signed [SCORE_W-1:0] sc, logic lst, bit gap);
    score_i <= sc;
    last_i <= lst;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(score_step(sc, lst));
    n_items++;
    @(negedge clk_i);
    if (gap) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // send a sequence of len words with random content, last on the final one
  task automatic send_seq(int unsigned len, bit burst);
    logic signed [SCORE_W-1:0] sc;
    for (int unsigned k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0: sc = 12'sh7FF;
        1: sc = -12'sh800;
        default: sc = SCORE_W'($urandom());
      endcase
      send_word(sc, k == len - 1, burst ? ($urandom_range(0, 7) == 0) : 1'b1);
    end
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  typedef struct {
    logic signed [SCORE_W-1:0] sc;
    logic lst;
    bit typed;
    score_res_t want;
  } stim_row_t;

  initial begin : stimulus
    stim_row_t rows[$];
    stim_row_t row;
    score_res_t e;
    int unsigned lo, hi, len;
    min_jump_r = 1;
    max_jump_r = 1;
    foreach (ring_ok[k]) begin
      ring_ok[k] = 1'b0;
      ring_val[k] = 0;
    end
    restart_seq();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table under reset settings; a single last word answers its own score
    row = '{12'sh7FF, 1'b1, 1'b1, '{31'sd2047, 1'b1, 31'sd2047, 1'b1, 1'b1}};
    rows.push_back(row);
    row = '{-12'sh800, 1'b1, 1'b1, '{-31'sd2048, 1'b1, -31'sd2048, 1'b1, 1'b1}};
    rows.push_back(row);
    row = '{12'sd0, 1'b1, 1'b1, '{31'sd0, 1'b1, 31'sd0, 1'b1, 1'b1}};
    rows.push_back(row);
    for (int k = 0; k < 8; k++) begin
      row.sc = (k % 2) ? -12'sh800 : 12'sh7FF;
      row.lst = (k == 7);
      row.typed = 1'b0;
      rows.push_back(row);
    end
    foreach (rows[k]) begin
      e = score_step(rows[k].sc, rows[k].lst);
      if (rows[k].typed && e != rows[k].want) begin
        errors++;
        $display("%0t: table row %0d disagrees with the scorer", $time, k);
      end
      pending_q.push_back(rows[k].typed ? rows[k].want : e);
      score_i <= rows[k].sc;
      last_i <= rows[k].lst;
      in_valid_i <= 1'b1;
      do @(posedge clk_i); while (!in_ready_o);
      n_items++;
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    drain();

    // min above max: nothing after position 0 is reachable
    write_reg(REG_MIN_JUMP, 11'd5);
    write_reg(REG_MAX_JUMP, 11'd2);
    send_seq(6, 1'b0);
    drain();
    // out of range: 0 clamps up, 2047 clamps down, unknown index dropped
    write_reg(REG_MIN_JUMP, 11'd0);
    write_reg(REG_MAX_JUMP, 11'h7FF);
    write_reg(2'd3, 11'd7);
    send_seq(8, 1'b0);
    drain();

    // random phases with changing settings, extremes included
    for (int unsigned ph = 0; n_items < 800 || ph < 8; ph++) begin
      case (ph % 6)
        0: begin lo = 1; hi = JUMP_CAP; end
        1: begin lo = JUMP_CAP; hi = JUMP_CAP; end
        2: begin lo = $urandom_range(0, 2047); hi = $urandom_range(0, 2047); end
        default: begin lo = $urandom_range(1, 4); hi = lo + $urandom_range(0, 5); end
      endcase
      write_reg(REG_MIN_JUMP, lo[CFG_W-1:0]);
      write_reg(REG_MAX_JUMP, hi[CFG_W-1:0]);
      // the receiver holds off for a long stretch while words keep coming
      if (ph == 3) long_hold = 1'b1;
      for (int s = 0; s < 6; s++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        send_seq(len, 1'b1);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
      drain();
      // sequence interrupted by a register change mid-way
      if (ph == 4) begin
        send_word(12'sd100, 1'b0, 1'b1);
        send_word(-12'sd3, 1'b0, 1'b1);
        in_valid_i <= 1'b0;
        drain();
        write_reg(REG_MAX_JUMP, 11'd1);
        send_seq(3, 1'b0);
        drain();
      end
    end

    $display("covered %0d words, %0d results, %0d answers over varied jump windows",
             n_items, n_results, n_answers);
    if (errors == 0 && pending_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[sliding_window_max_jump_dp.f]
sv/swmj_pkg.sv
sv/swmj_deque.sv
sv/sliding_window_max_jump_dp.sv
verif/tb.sv
